FILE: design/tcp_segment_overlap_trim_macros.svh
// Assertion macros shared by the overlap trim block.
// No dependencies; include by bare file name.
`ifndef TCP_SEGMENT_OVERLAP_TRIM_MACROS_SVH
`define TCP_SEGMENT_OVERLAP_TRIM_MACROS_SVH

// Check c in the same cycle whenever a holds.
`define TSOT_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tsot: same-cycle check failed");

// Check c in the cycle after a holds.
`define TSOT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tsot: next-cycle check failed");

`endif

FILE: design/tsot_pkg.sv
// Shared types and verdict codes for the TCP segment overlap trim block.
// No dependencies.
package tsot_pkg;

    localparam int SEQ_W  = 32;
    localparam int SIZE_W = 16;
    localparam int VERD_W = 3;

    localparam logic [VERD_W-1:0] V_NO_OVL_AFTER  = 3'd0;
    localparam logic [VERD_W-1:0] V_NO_OVL_BEFORE = 3'd1;
    localparam logic [VERD_W-1:0] V_SUBSET        = 3'd2;
    localparam logic [VERD_W-1:0] V_FRONT_TRIM    = 3'd3;
    localparam logic [VERD_W-1:0] V_UNDER         = 3'd4;
    localparam logic [VERD_W-1:0] V_OLD_INSIDE    = 3'd5;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  base_seq;
        logic [SEQ_W-1:0]  new_seq;
        logic [SIZE_W-1:0] new_size;
        logic [SIZE_W-1:0] new_offset;
        logic [SEQ_W-1:0]  old_seq;
        logic [SIZE_W-1:0] old_size;
    } t_seg_in;

    typedef struct packed {
        logic [VERD_W-1:0] verdict;
        logic [SIZE_W-1:0] overlap_bytes;
        logic [SEQ_W-1:0]  out_seq;
        logic [SIZE_W-1:0] out_size;
        logic [SIZE_W-1:0] out_offset;
    } t_seg_out;

endpackage

FILE: design/tsot_judge.sv
// Overlap classification and trim arithmetic for one segment pair.
// Purely combinational; uses tsot_pkg.
module tsot_judge
    import tsot_pkg::*;
(
    input  t_seg_in  i_seg,
    output t_seg_out o_res
);

    logic [SEQ_W-1:0]  rs, re, os, oe, sg, eg;
    logic [SEQ_W-1:0]  new_sz32, old_sz32;
    logic [SEQ_W-1:0]  cnt_under, cnt_tail;
    logic [SEQ_W-1:0]  count;
    logic [VERD_W-1:0] verdict;
    logic              front;
    logic              cut_size;
    logic              eg_le0;

    assign new_sz32 = {{(SEQ_W-SIZE_W){1'b0}}, i_seg.new_size};
    assign old_sz32 = {{(SEQ_W-SIZE_W){1'b0}}, i_seg.old_size};

    // Relative positions against the base, all mod 2^32
    assign rs = i_seg.new_seq - i_seg.base_seq;
    assign os = i_seg.old_seq - i_seg.base_seq;
    assign re = rs + new_sz32 - 32'd1;
    assign oe = os + old_sz32 - 32'd1;
    assign sg = rs - os;
    assign eg = re - oe;
    assign eg_le0 = (eg == '0) || eg[SEQ_W-1];

    // Overlap counts formed without the base: re-os+1 and oe-rs+1
    assign cnt_under = (i_seg.new_seq - i_seg.old_seq) + new_sz32;
    assign cnt_tail  = (i_seg.old_seq - i_seg.new_seq) + old_sz32;

    always_comb begin
        verdict  = V_NO_OVL_AFTER;
        count    = '0;
        front    = 1'b0;
        cut_size = 1'b0;
        if (oe < rs) begin
            verdict = V_NO_OVL_AFTER;
        end else if (os > re) begin
            if (!i_seg.kind) begin
                verdict = V_NO_OVL_BEFORE;
            end else begin
                verdict = V_UNDER;
                count   = new_sz32;
            end
        end else if (sg == '0) begin
            if (eg_le0) begin
                verdict = V_SUBSET;
                count   = new_sz32;
            end else begin
                verdict = V_FRONT_TRIM;
                count   = old_sz32;
                front   = 1'b1;
            end
        end else if (sg[SEQ_W-1]) begin
            if (eg_le0) begin
                verdict = V_UNDER;
                if (!i_seg.kind) begin
                    count    = cnt_under;
                    cut_size = 1'b1;
                end else begin
                    count = new_sz32;
                end
            end else if (!i_seg.kind) begin
                verdict = V_OLD_INSIDE;
                count   = old_sz32;
            end else begin
                verdict = V_FRONT_TRIM;
                count   = cnt_tail;
                front   = 1'b1;
            end
        end else begin
            if (eg_le0) begin
                verdict = V_SUBSET;
                count   = new_sz32;
            end else begin
                verdict = V_FRONT_TRIM;
                count   = cnt_tail;
                front   = 1'b1;
            end
        end
    end

    always_comb begin
        o_res.verdict       = verdict;
        o_res.overlap_bytes = count[SIZE_W-1:0];
        o_res.out_seq       = front ? i_seg.new_seq + count : i_seg.new_seq;
        o_res.out_size      = (front || cut_size) ? i_seg.new_size - count[SIZE_W-1:0]
                                                  : i_seg.new_size;
        o_res.out_offset    = front ? i_seg.new_offset + count[SIZE_W-1:0]
                                    : i_seg.new_offset;
    end

endmodule

FILE: design/tcp_segment_overlap_trim.sv
// TCP segment overlap trim: from input accept to result valid the item passes
// the input register, then the result register. Throughput: one item per cycle
// unless the output stalls. The two registers form a stall-aware pipeline, so a
// new item is taken while a finished result still waits downstream.
// Reset (synchronous, active low) empties both stages; payload is not cleared.
// Depends on tsot_pkg, tsot_judge and tcp_segment_overlap_trim_macros.svh.
`include "tcp_segment_overlap_trim_macros.svh"

module tcp_segment_overlap_trim
    import tsot_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input item channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_kind,
    input  logic [SEQ_W-1:0]  i_base_seq,
    input  logic [SEQ_W-1:0]  i_new_seq,
    input  logic [SIZE_W-1:0] i_new_size,
    input  logic [SIZE_W-1:0] i_new_offset,
    input  logic [SEQ_W-1:0]  i_old_seq,
    input  logic [SIZE_W-1:0] i_old_size,
    // result item channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VERD_W-1:0] o_verdict,
    output logic [SIZE_W-1:0] o_overlap_bytes,
    output logic [SEQ_W-1:0]  o_out_seq,
    output logic [SIZE_W-1:0] o_out_size,
    output logic [SIZE_W-1:0] o_out_offset
);

    // Stage 1: captured input item
    logic     r_s1_valid, n_s1_valid;
    t_seg_in  r_s1_seg;
    // Stage 2: finished result
    logic     r_out_valid, n_out_valid;
    t_seg_out r_out_res;

    t_seg_out judge_res;
    logic     out_load;
    logic     s1_load;

    // The result register can take a new item when it is empty or draining.
    assign out_load = !r_out_valid || !i_out_stall;
    // Stage 1 frees up when it is empty or its item moves to the result register.
    assign s1_load  = !r_s1_valid || out_load;
    assign o_in_stall = !s1_load;

    tsot_judge u_judge (
        .i_seg (r_s1_seg),
        .o_res (judge_res)
    );

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (s1_load) begin
            n_s1_valid = i_in_valid;
        end
        if (out_load) begin
            n_out_valid = r_s1_valid;
        end
    end

    // Control state: clear both stages on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: capture the item on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_s1_seg.kind       <= i_kind;
            r_s1_seg.base_seq   <= i_base_seq;
            r_s1_seg.new_seq    <= i_new_seq;
            r_s1_seg.new_size   <= i_new_size;
            r_s1_seg.new_offset <= i_new_offset;
            r_s1_seg.old_seq    <= i_old_seq;
            r_s1_seg.old_size   <= i_old_size;
        end
    end

    // Advance the judged result; hold it while downstream stalls.
    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out_res <= judge_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_verdict       = r_out_res.verdict;
    assign o_overlap_bytes = r_out_res.overlap_bytes;
    assign o_out_seq       = r_out_res.out_seq;
    assign o_out_size      = r_out_res.out_size;
    assign o_out_offset    = r_out_res.out_offset;

    // An item leaving stage 1 shows up as a valid result next cycle.
    `TSOT_ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n, r_s1_valid && out_load, o_out_valid)
    // Stall upstream only when both stages are full and the output is blocked.
    `TSOT_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        r_s1_valid && r_out_valid && i_out_stall)
    // A no-overlap verdict never counts bytes.
    `TSOT_ASSERT_NOW(a_no_ovl_zero, i_clk, i_rst_n,
        o_out_valid && (o_verdict == V_NO_OVL_AFTER || o_verdict == V_NO_OVL_BEFORE),
        o_overlap_bytes == '0)

endmodule
